/* src/pop_pkg.sv */
`default_nettype none

package pop_pkg;

  localparam int IP_W   = 64;
  localparam int CNT_W  = 32;
  localparam int DOT_W  = 12;
  localparam int DOT_MAX = 2047;
  localparam int DOT_MIN = -2048;

  typedef enum logic [1:0] {
    FN_PREDICT = 2'd0,
    FN_UPDATE  = 2'd1,
    FN_CLEAR   = 2'd2,
    FN_COUNT   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_REDUCE,
    FR_PUSH
  } fr_state_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_PART,
    BK_DONE
  } bk_state_t;

endpackage

`default_nettype wire

/* src/pop_req_if.sv */
`default_nettype none

interface pop_req_if;
  logic                          valid;
  logic                          ready;
  pop_pkg::func_t                func;
  logic [pop_pkg::IP_W-1:0]      ip;
  logic                          predicted_flag;
  logic                          actual_outcome;

  modport source (output valid, func, ip, predicted_flag, actual_outcome, input ready);
  modport sink   (input valid, func, ip, predicted_flag, actual_outcome, output ready);
endinterface

`default_nettype wire

/* src/pop_resp_if.sv */
`default_nettype none

interface pop_resp_if;
  logic                              valid;
  logic                              ready;
  logic                              prediction;
  logic signed [pop_pkg::DOT_W-1:0]  dot_sum;
  logic [pop_pkg::CNT_W-1:0]         correct_count;
  logic [pop_pkg::CNT_W-1:0]         incorrect_count;

  modport source (output valid, prediction, dot_sum, correct_count, incorrect_count,
                  input ready);
  modport sink   (input valid, prediction, dot_sum, correct_count, incorrect_count,
                  output ready);
endinterface

`default_nettype wire

/* src/pop_ram.sv */
`default_nettype none

module pop_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [ADDR_W-1:0]       waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic                    re,
  input  wire logic [ADDR_W-1:0]       raddr,
  output logic      [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/pop_queue.sv */
`default_nettype none

// Two-entry FIFO between front and back.
module pop_queue #(
  parameter int DATA_W = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   space,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      pop_data,
  output logic                   not_empty
);

  logic [DATA_W-1:0] entry [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign space     = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/pop_front.sv */
`default_nettype none

// Accepts items and reduces ip to a row index, then queues them for the back end.
module pop_front #(
  parameter int TABLE_ENTRIES = 256,
  localparam int ROW_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int ENT_W = 4 + ROW_W
) (
  input  wire logic          clk,
  input  wire logic          rst,
  pop_req_if.sink            req,
  input  wire logic          clearing,
  input  wire logic          q_space,
  output logic               push,
  output logic [ENT_W-1:0]   push_data
);

  localparam bit POW2  = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

  generate
    if (TABLE_ENTRIES == 1) begin : g_single
      assign req.ready = !clearing && q_space;
      assign push      = req.valid && req.ready;
      assign push_data = {req.func, req.predicted_flag, req.actual_outcome, ROW_W'(0)};
    end else if (POW2) begin : g_mask
      assign req.ready = !clearing && q_space;
      assign push      = req.valid && req.ready;
      assign push_data = {req.func, req.predicted_flag, req.actual_outcome,
                          req.ip[ROW_W-1:0]};
    end else begin : g_reduce
      // Remainder by restoring reduction, four address bits per cycle.
      localparam int REM_W = ROW_W + 1;
      localparam int STEPS = pop_pkg::IP_W / 4;

      pop_pkg::fr_state_t           state, state_next;
      pop_pkg::func_t               hold_func;
      logic                         hold_pred;
      logic                         hold_act;
      logic [pop_pkg::IP_W-1:0]     ip_sh;
      logic [ROW_W-1:0]             rem;
      logic [ROW_W-1:0]             rem_next;
      logic [3:0]                   cnt;

      assign req.ready = (state == pop_pkg::FR_IDLE) && !clearing;
      assign push      = (state == pop_pkg::FR_PUSH) && q_space;
      assign push_data = {hold_func, hold_pred, hold_act, rem};

      always_comb begin
        logic [REM_W-1:0] t;
        logic [ROW_W-1:0] r;
        r = rem;
        for (int k = 0; k < 4; k++) begin
          t = {r, ip_sh[pop_pkg::IP_W-1-k]};
          if (t >= REM_W'(TABLE_ENTRIES)) begin
            t = t - REM_W'(TABLE_ENTRIES);
          end
          r = t[ROW_W-1:0];
        end
        rem_next = r;
      end

      always_comb begin
        state_next = state;
        case (state)
          pop_pkg::FR_IDLE: begin
            if (req.valid && req.ready) state_next = pop_pkg::FR_REDUCE;
          end
          pop_pkg::FR_REDUCE: begin
            if (cnt == 4'(STEPS - 1)) state_next = pop_pkg::FR_PUSH;
          end
          pop_pkg::FR_PUSH: begin
            if (q_space) state_next = pop_pkg::FR_IDLE;
          end
          default: state_next = pop_pkg::FR_IDLE;
        endcase
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          state <= pop_pkg::FR_IDLE;
        end else begin
          state <= state_next;
        end
      end

      always_ff @(posedge clk) begin
        if (state == pop_pkg::FR_IDLE && req.valid && req.ready) begin
          hold_func <= req.func;
          hold_pred <= req.predicted_flag;
          hold_act  <= req.actual_outcome;
          ip_sh     <= req.ip;
          rem       <= '0;
          cnt       <= '0;
        end else if (state == pop_pkg::FR_REDUCE) begin
          ip_sh <= ip_sh << 4;
          rem   <= rem_next;
          cnt   <= cnt + 4'd1;
        end
      end
    end
  endgenerate

endmodule

`default_nettype wire

/* src/pop_back.sv */
`default_nettype none

// Reads the weight row, forms the dot product, trains the row on an update and keeps the tallies.
module pop_back #(
  parameter int TABLE_ENTRIES = 256,
  parameter int HISTORY_LEN   = 16,
  parameter int WEIGHT_BITS   = 8,
  localparam int ROW_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int ENT_W = 4 + ROW_W
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire logic [ENT_W-1:0] q_data,
  output logic               q_pop,
  output logic               clearing,
  pop_resp_if.source         resp
);

  localparam int ROW_BITS = HISTORY_LEN * WEIGHT_BITS;
  localparam int SUM_W    = WEIGHT_BITS + 1 + $clog2(HISTORY_LEN);
  localparam int EXT_W    = (SUM_W > pop_pkg::DOT_W + 1) ? SUM_W : pop_pkg::DOT_W + 1;
  localparam int GRP      = 8;
  localparam int NGRP     = (HISTORY_LEN + GRP - 1) / GRP;

  localparam logic signed [WEIGHT_BITS-1:0] WMAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] WMIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
  localparam logic signed [EXT_W-1:0] CLIP_HI = EXT_W'(pop_pkg::DOT_MAX);
  localparam logic signed [EXT_W-1:0] CLIP_LO = EXT_W'(pop_pkg::DOT_MIN);
  localparam logic [HISTORY_LEN-1:0] HIST_INIT = HISTORY_LEN'(64'h5555555555555555);
  localparam logic [ROW_BITS-1:0] ROW_INIT = {HISTORY_LEN{WEIGHT_BITS'(1)}};

  pop_pkg::bk_state_t state, state_next;

  logic [ROW_W-1:0]              clr_idx;
  pop_pkg::func_t                cur_func;
  logic                          cur_pred;
  logic                          cur_act;
  logic [ROW_W-1:0]              cur_row;
  logic [ROW_BITS-1:0]           rdata;
  logic [ROW_BITS-1:0]           row_q;
  logic [ROW_BITS-1:0]           new_row;
  logic signed [SUM_W-1:0]       part [NGRP];
  logic signed [SUM_W-1:0]       part_q [NGRP];
  logic signed [SUM_W-1:0]       total;
  logic signed [SUM_W-1:0]       sum_q;
  logic signed [EXT_W-1:0]       sum_ext;
  logic signed [pop_pkg::DOT_W-1:0] dot_clip;
  logic [HISTORY_LEN-1:0]        history;
  logic [pop_pkg::CNT_W-1:0]     right_tally, right_tally_next;
  logic [pop_pkg::CNT_W-1:0]     wrong_tally, wrong_tally_next;
  logic                          commit;
  logic                          ram_we;
  logic [ROW_W-1:0]              ram_waddr;
  logic [ROW_BITS-1:0]           ram_wdata;
  logic                          ram_re;

  logic                          out_valid;
  logic                          out_pred;
  logic signed [pop_pkg::DOT_W-1:0] out_dot;
  logic [pop_pkg::CNT_W-1:0]     out_right;
  logic [pop_pkg::CNT_W-1:0]     out_wrong;

  assign clearing = (state == pop_pkg::BK_CLEAR);
  assign commit   = (state == pop_pkg::BK_DONE) && (!out_valid || resp.ready);
  assign q_pop    = (state == pop_pkg::BK_IDLE) && q_valid;

  assign ram_re    = q_pop;
  assign ram_we    = clearing || (commit && cur_func == pop_pkg::FN_UPDATE);
  assign ram_waddr = clearing ? clr_idx : cur_row;
  assign ram_wdata = clearing ? ROW_INIT : new_row;

  pop_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (TABLE_ENTRIES)
  ) u_weights (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_data[ROW_W-1:0]),
    .rdata (rdata)
  );

  // Group partial sums of +w / -w, eight lanes per group.
  always_comb begin
    logic signed [SUM_W-1:0]       acc;
    logic signed [WEIGHT_BITS-1:0] w;
    int                            idx;
    for (int g = 0; g < NGRP; g++) begin
      acc = '0;
      for (int k = 0; k < GRP; k++) begin
        idx = g * GRP + k;
        if (idx < HISTORY_LEN) begin
          w = rdata[idx*WEIGHT_BITS +: WEIGHT_BITS];
          if (history[idx]) acc = acc + SUM_W'(w);
          else              acc = acc - SUM_W'(w);
        end
      end
      part[g] = acc;
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    acc = '0;
    for (int g = 0; g < NGRP; g++) begin
      acc = acc + part_q[g];
    end
    total = acc;
  end

  // Saturating +1 / -1 training step on every weight of the row.
  always_comb begin
    logic signed [WEIGHT_BITS-1:0] w;
    for (int i = 0; i < HISTORY_LEN; i++) begin
      w = row_q[i*WEIGHT_BITS +: WEIGHT_BITS];
      if (cur_act) begin
        if (w != WMAX) w = w + WEIGHT_BITS'(1);
      end else begin
        if (w != WMIN) w = w - WEIGHT_BITS'(1);
      end
      new_row[i*WEIGHT_BITS +: WEIGHT_BITS] = w;
    end
  end

  assign sum_ext = EXT_W'(sum_q);

  always_comb begin
    if (sum_ext > CLIP_HI)      dot_clip = pop_pkg::DOT_W'(pop_pkg::DOT_MAX);
    else if (sum_ext < CLIP_LO) dot_clip = pop_pkg::DOT_W'(pop_pkg::DOT_MIN);
    else                        dot_clip = sum_ext[pop_pkg::DOT_W-1:0];
  end

  always_comb begin
    right_tally_next = right_tally;
    wrong_tally_next = wrong_tally;
    case (cur_func)
      pop_pkg::FN_UPDATE, pop_pkg::FN_COUNT: begin
        if (cur_pred == cur_act) right_tally_next = right_tally + 32'd1;
        else                     wrong_tally_next = wrong_tally + 32'd1;
      end
      pop_pkg::FN_CLEAR: begin
        right_tally_next = '0;
        wrong_tally_next = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      pop_pkg::BK_CLEAR: begin
        if (clr_idx == ROW_W'(TABLE_ENTRIES - 1)) state_next = pop_pkg::BK_IDLE;
      end
      pop_pkg::BK_IDLE: begin
        if (q_valid) state_next = pop_pkg::BK_READ;
      end
      pop_pkg::BK_READ: state_next = pop_pkg::BK_PART;
      pop_pkg::BK_PART: state_next = pop_pkg::BK_DONE;
      pop_pkg::BK_DONE: begin
        if (commit) state_next = pop_pkg::BK_IDLE;
      end
      default: state_next = pop_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pop_pkg::BK_CLEAR;
      clr_idx     <= '0;
      history     <= HIST_INIT;
      right_tally <= '0;
      wrong_tally <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + ROW_W'(1);
      end
      if (commit) begin
        right_tally <= right_tally_next;
        wrong_tally <= wrong_tally_next;
        if (cur_func == pop_pkg::FN_UPDATE) begin
          history <= (history << 1) | HISTORY_LEN'(cur_act);
        end
        out_valid <= 1'b1;
      end else if (resp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_func <= pop_pkg::func_t'(q_data[ENT_W-1 -: 2]);
      cur_pred <= q_data[ROW_W+1];
      cur_act  <= q_data[ROW_W];
      cur_row  <= q_data[ROW_W-1:0];
    end
    if (state == pop_pkg::BK_READ) begin
      row_q  <= rdata;
      part_q <= part;
    end
    if (state == pop_pkg::BK_PART) begin
      sum_q <= total;
    end
    if (commit) begin
      out_pred  <= !sum_q[SUM_W-1];
      out_dot   <= dot_clip;
      out_right <= right_tally_next;
      out_wrong <= wrong_tally_next;
    end
  end

  assign resp.valid           = out_valid;
  assign resp.prediction      = out_pred;
  assign resp.dot_sum         = out_dot;
  assign resp.correct_count   = out_right;
  assign resp.incorrect_count = out_wrong;

endmodule

`default_nettype wire

/* src/perceptron_outcome_predictor.sv */
// Perceptron outcome predictor.
// req carries one item per handshake (valid && ready): func, ip, predicted_flag,
// actual_outcome. resp returns exactly one item for every request, in order:
// prediction, dot_sum (saturated to 12 bits), correct_count, incorrect_count.
// Every func reports the dot product of the selected row as it was before the item.
// The front end reduces ip to a row index (a mask for a power-of-two table, else a
// restoring remainder unit) and pushes into a two-entry queue. For each item the back
// end steps through IDLE, READ, PART and DONE: row read from the weight RAM, group
// partial sums, final sum, then write-back of the trained row (on an update) and the
// result register. The back end takes a new item from the queue only in IDLE; the
// queue lets the front end accept more items in the meantime.
// After reset the back end sets every weight in the weight RAM to +1, one row per
// cycle, with req.ready held low; history and tallies reset at once.
// A stalled resp holds its item in the output register; up to two more items wait
// in the queue before req.ready drops.
`default_nettype none

module perceptron_outcome_predictor #(
  parameter int TABLE_ENTRIES = 256,
  parameter int HISTORY_LEN   = 16,
  parameter int WEIGHT_BITS   = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pop_req_if.sink     req,
  pop_resp_if.source  resp
);

  localparam int ROW_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ENT_W = 4 + ROW_W;

  logic             clearing;
  logic             push;
  logic [ENT_W-1:0] push_data;
  logic             q_space;
  logic             q_pop;
  logic [ENT_W-1:0] q_data;
  logic             q_valid;

  pop_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .clearing  (clearing),
    .q_space   (q_space),
    .push      (push),
    .push_data (push_data)
  );

  pop_queue #(
    .DATA_W (ENT_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (q_space),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  pop_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .HISTORY_LEN   (HISTORY_LEN),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .clearing (clearing),
    .resp     (resp)
  );

endmodule

`default_nettype wire
